// ----- rtl/usa_pkg.sv -----
// Shared types, constants and byte classification for the UTF-8 sequence assembler.
`default_nettype none
package usa_pkg;

	localparam int unsigned MaxSeq = 4;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_CONTINUE = 2'd1,
		ST_BROKEN   = 2'd2,
		ST_INVALID  = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]      count;
		logic [3:0][7:0] held;
	} state_t;

	typedef struct packed {
		status_t status;
		logic    aborted;
	} flags_t;

	// Sequence length opened by a lead byte; 0 when the byte is no lead.
	function automatic logic [2:0] lead_len(input logic [7:0] v);
		logic [2:0] len;
		if ((v & 8'h80) == 8'h00) begin
			len = 3'd1;
		end else if ((v & 8'hE0) == 8'hC0) begin
			len = 3'd2;
		end else if ((v & 8'hF0) == 8'hE0) begin
			len = 3'd3;
		end else if ((v & 8'hF8) == 8'hF0) begin
			len = 3'd4;
		end else begin
			len = 3'd0;
		end
		return len;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/usa_step.sv -----
// Next-state and status logic for one byte of the UTF-8 sequence assembler.
`default_nettype none
module usa_step (
	input  wire logic [7:0]    in_byte,
	input  wire usa_pkg::state_t cur,
	output usa_pkg::state_t    nxt,
	output usa_pkg::flags_t    flags
);

	logic [2:0]      n;
	logic            clr;
	logic [2:0]      c0;
	logic [3:0][7:0] h;
	logic            is_cont;
	logic [2:0]      c1;

	always_comb begin
		n       = usa_pkg::lead_len(cur.held[0]);
		clr     = (cur.count > 3'(usa_pkg::MaxSeq)) || (n == 3'd0) || (cur.count >= n);
		c0      = clr ? 3'd0 : cur.count;
		h       = clr ? '0 : cur.held;
		is_cont = (in_byte[7:6] == 2'b10);
		c1      = 3'(c0 + 3'd1);

		nxt           = '{count: c0, held: h};
		flags.aborted = 1'b0;
		flags.status  = usa_pkg::ST_DONE;

		if ((c0 != 3'd0) && is_cont) begin
			// c0 < n <= 4, so the two low bits address the free slot
			nxt.held[c0[1:0]] = in_byte;
			nxt.count         = c1;
			flags.status      = (c1 == n) ? usa_pkg::ST_DONE : usa_pkg::ST_CONTINUE;
		end else begin
			flags.aborted = (c0 != 3'd0);
			if (!in_byte[7]) begin
				flags.status = usa_pkg::ST_DONE;
			end else if (is_cont) begin
				flags.status = usa_pkg::ST_BROKEN;
			end else if (usa_pkg::lead_len(in_byte) != 3'd0) begin
				flags.status = usa_pkg::ST_CONTINUE;
			end else begin
				flags.status = usa_pkg::ST_INVALID;
			end
			if (flags.status == usa_pkg::ST_INVALID) begin
				nxt = '0;
			end else begin
				nxt.count = 3'd1;
				nxt.held  = {24'd0, in_byte};
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/utf8_sequence_assembler.sv -----
// An accepted item passes through the input reg and then the result reg.
// Throughput: one item per cycle while the output is not stalled; the byte-count update in usa_step is combinational.
// The input register takes a new item while a result waits on a stalled output.
// Reset (arst_n low, asynchronous): no items held, byte count zero, stored bytes zero.
// No clearing pass; the block accepts items as soon as reset is released.
`default_nettype none
module utf8_sequence_assembler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic             prior_aborted,
	output logic [31:0]      seq_bytes,
	output logic [2:0]       seq_count
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	usa_pkg::state_t  state_q;
	usa_pkg::state_t  state_nxt;
	usa_pkg::flags_t  flags;
	logic             out_valid_q;
	usa_pkg::flags_t  flags_q;
	usa_pkg::state_t  res_q;
	logic             out_free;
	logic             adv;

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	usa_step u_step (
		.in_byte (byte_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.flags   (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
		if (adv) begin
			flags_q <= flags;
			res_q   <= state_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = flags_q.status;
	assign prior_aborted = flags_q.aborted;
	assign seq_bytes     = res_q.held;
	assign seq_count     = res_q.count;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.count <= 3'(usa_pkg::MaxSeq))
		else $error("byte count above four");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.count == 3'd0) |-> (state_q.held == '0))
		else $error("empty store holds nonzero bytes");

	a_invalid_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (flags_q.status == usa_pkg::ST_INVALID))
			|-> (res_q.count == 3'd0 && res_q.held == '0))
		else $error("invalid item left bytes in the result");

	a_abort_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && flags_q.aborted) |-> (flags_q.status != usa_pkg::ST_BROKEN))
		else $error("abort paired with broken status");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("state changed without an item");

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the UTF-8 sequence assembler: directed bytes, then random streams.
`default_nettype none
module tb;

	localparam int unsigned CycleLimit = 200000;

	typedef struct packed {
		logic [7:0]       src;
		usa_pkg::status_t status;
		logic             aborted;
		logic [31:0]      bytes;
		logic [2:0]       count;
	} utf8_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic        prior_aborted;
	logic [31:0] seq_bytes;
	logic [2:0]  seq_count;

	// predictor state
	logic [2:0]       asm_count;
	logic [3:0][7:0]  asm_held;

	utf8_result_t pending_results[$];
	int unsigned  mismatch_cnt;
	int unsigned  cycle_cnt;
	int unsigned  send_idle_pct;
	int unsigned  recv_stall_pct;

	utf8_sequence_assembler u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.prior_aborted(prior_aborted),
		.seq_bytes    (seq_bytes),
		.seq_count    (seq_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sequence length that a first byte opens; 0 when it cannot open one.
	function automatic int unsigned seq_len_of(input logic [7:0] b);
		casez (b)
			8'b0???????: return 1;
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default: return 0;
		endcase
	endfunction

	function automatic utf8_result_t assemble_byte(input logic [7:0] b);
		utf8_result_t r;
		int unsigned  need;
		logic         taken;
		r = '0;
		r.src = b;
		taken = 1'b0;
		need = seq_len_of(asm_held[0]);
		if (asm_count > 3'd4 || need == 0 || asm_count >= need) begin
			asm_count = '0;
			asm_held = '0;
		end
		if (asm_count != 3'd0) begin
			if (b[7:6] == 2'b10) begin
				asm_held[asm_count[1:0]] = b;
				asm_count = asm_count + 3'd1;
				r.status = (asm_count == need) ? usa_pkg::ST_DONE
					: usa_pkg::ST_CONTINUE;
				taken = 1'b1;
			end else begin
				// pending sequence broken; byte restarts as a first byte
				r.aborted = 1'b1;
				asm_count = '0;
				asm_held = '0;
			end
		end
		if (!taken) begin
			if (!b[7])
				r.status = usa_pkg::ST_DONE;
			else if (b[7:6] == 2'b10)
				r.status = usa_pkg::ST_BROKEN;
			else if (seq_len_of(b) != 0)
				r.status = usa_pkg::ST_CONTINUE;
			else
				r.status = usa_pkg::ST_INVALID;
			if (r.status != usa_pkg::ST_INVALID) begin
				asm_count = 3'd1;
				asm_held[0] = b;
			end
		end
		r.bytes = asm_held;
		r.count = asm_count;
		return r;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(assemble_byte(b));
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_lead(input int unsigned len);
		logic [7:0] v;
		v = 8'($urandom);
		case (len)
			1: return {1'b0, v[6:0]};
			2: return {3'b110, v[4:0]};
			3: return {4'b1110, v[3:0]};
			default: return {5'b11110, v[2:0]};
		endcase
	endfunction

	// Mostly well-formed sequences, some cut short, some raw noise.
	task automatic random_streams(input int unsigned n_items);
		int unsigned sent;
		int unsigned kind;
		int unsigned len;
		int unsigned conts;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 99);
			if (kind < 90) begin
				len = (kind < 75) ? $urandom_range(1, 4) : $urandom_range(2, 4);
				conts = (kind < 75) ? len - 1 : $urandom_range(0, len - 2);
				send_byte(pick_lead(len));
				sent++;
				repeat (conts) begin
					send_byte({2'b10, 6'($urandom)});
					sent++;
				end
			end else begin
				send_byte(8'($urandom));
				sent++;
			end
		end
	endtask

	task automatic test_directed();
		logic [7:0] seq_list[$] = '{
			8'h00, 8'h7F,
			8'hC2, 8'hA9,
			8'hE2, 8'h82, 8'hAC,
			8'hF0, 8'h9F, 8'h98, 8'h80,
			8'h80, 8'hBF,
			8'hF8, 8'hFF,
			8'hDF, 8'h41,
			8'hE0, 8'hF8,
			8'hEF, 8'hBF, 8'hF7,
			8'hBF,
			8'hC0, 8'h80
		};
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (seq_list[i]) send_byte(seq_list[i]);
		wait_for_results();
	endtask

	task automatic test_streams_no_idle();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_streams(360);
		wait_for_results();
	endtask

	task automatic test_streams_sender_idle();
		send_idle_pct = 75;
		recv_stall_pct = 0;
		random_streams(360);
		wait_for_results();
	endtask

	task automatic test_streams_receiver_stall();
		send_idle_pct = 0;
		recv_stall_pct = 75;
		random_streams(360);
		wait_for_results();
	endtask

	task automatic test_streams_both_idle();
		send_idle_pct = 27;
		recv_stall_pct = 27;
		random_streams(360);
		wait_for_results();
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		utf8_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected result: status=%0d aborted=%0d bytes=%h count=%0d",
						status, prior_aborted, seq_bytes, seq_count);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status || prior_aborted !== want.aborted ||
					seq_bytes !== want.bytes || seq_count !== want.count) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display({"mismatch on byte %h: ",
							"exp status=%0d aborted=%0d bytes=%h count=%0d, ",
							"got status=%0d aborted=%0d bytes=%h count=%0d"},
							want.src, want.status, want.aborted, want.bytes,
							want.count, status, prior_aborted, seq_bytes,
							seq_count);
				end
			end
		end
	end

	initial begin
		mismatch_cnt = 0;
		cycle_cnt = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		asm_count = '0;
		asm_held = '0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_byte <= '0;
		out_stall <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_streams_no_idle();
		test_streams_sender_idle();
		test_streams_receiver_stall();
		test_streams_both_idle();

		recv_stall_pct = 0;
		wait_for_results();
		// catch any stray result past the last one
		repeat (6) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/usa_pkg.sv
rtl/usa_step.sv
rtl/utf8_sequence_assembler.sv
dv/tb.sv
